/* hdl/bpe_pkg.sv */
// Package for the bencode path extractor: shared types, codes and constants.
// Has no dependencies; every other file in hdl/ imports it.
package bpe_pkg;

  // Width of the string length counter.
  localparam int LEN_BITS = 32;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

  // Byte classes produced by the front end.
  localparam logic [2:0] CLS_END   = 3'd0;
  localparam logic [2:0] CLS_DIGIT = 3'd1;
  localparam logic [2:0] CLS_INT   = 3'd2;
  localparam logic [2:0] CLS_LIST  = 3'd3;
  localparam logic [2:0] CLS_DICT  = 3'd4;
  localparam logic [2:0] CLS_CLOSE = 3'd5;
  localparam logic [2:0] CLS_COLON = 3'd6;
  localparam logic [2:0] CLS_OTHER = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_ERR  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_BAD_START  = 4'd1;
  localparam logic [3:0] ERR_LEN_OVF    = 4'd2;
  localparam logic [3:0] ERR_NO_COLON   = 4'd3;
  localparam logic [3:0] ERR_SHORT_STR  = 4'd4;
  localparam logic [3:0] ERR_NO_LIST    = 4'd5;
  localparam logic [3:0] ERR_BAD_ITEM   = 4'd6;
  localparam logic [3:0] ERR_EMPTY_NAME = 4'd7;
  localparam logic [3:0] ERR_EMPTY_PATH = 4'd8;
  localparam logic [3:0] ERR_TRUNC_INT  = 4'd9;

  // Characters the parser looks for or emits.
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  // Classified input transaction.
  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] data;
    logic [3:0] digit;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] code;
  } res_t;

  // Status from the back end to the top level.
  typedef struct packed {
    logic halted;
    logic res_push;
  } stat_t;

  // The key word "path", one byte per position.
  function automatic logic [7:0] key_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0: b = 8'h70;
      2'd1: b = 8'h61;
      2'd2: b = 8'h74;
      2'd3: b = 8'h68;
      default: b = 8'h70;
    endcase
    return b;
  endfunction

endpackage

/* hdl/bpe_front.sv */
// Front end of the bencode path extractor: classifies each incoming byte.
// Depends on bpe_pkg.
module bpe_front
  import bpe_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       is_end,
  output cmd_t       cmd
);

  // Sort the byte into the classes the parser acts on.
  always_comb begin
    cmd.data  = in_byte;
    cmd.digit = in_byte[3:0] - 4'd0;
    if (is_end) begin
      cmd.cls = CLS_END;
    end else if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      cmd.cls = CLS_DIGIT;
    end else begin
      case (in_byte)
        8'h69: cmd.cls = CLS_INT;
        8'h6C: cmd.cls = CLS_LIST;
        8'h64: cmd.cls = CLS_DICT;
        8'h65: cmd.cls = CLS_CLOSE;
        8'h3A: cmd.cls = CLS_COLON;
        default: cmd.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

/* hdl/bpe_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on bpe_pkg.
module bpe_queue
  import bpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                    mem [CMD_DEPTH];
  logic [CMD_PTR_BITS-1:0] wptr;
  logic [CMD_PTR_BITS-1:0] rptr;
  logic [CMD_PTR_BITS:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count == (CMD_PTR_BITS+1)'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/bpe_back.sv */
// Back end of the bencode path extractor: parser state machine and result queue.
// Depends on bpe_pkg.
module bpe_back
  import bpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_char,
  output logic [3:0] error_code,
  output stat_t      stat
);

  localparam logic [2:0] PH_TOP       = 3'd0;
  localparam logic [2:0] PH_INT       = 3'd1;
  localparam logic [2:0] PH_LEN       = 3'd2;
  localparam logic [2:0] PH_BODY      = 3'd3;
  localparam logic [2:0] PH_WANT_LIST = 3'd4;
  localparam logic [2:0] PH_ITEM      = 3'd5;
  localparam logic [2:0] PH_PLEN      = 3'd6;
  localparam logic [2:0] PH_PBODY     = 3'd7;

  logic [2:0]          phase;
  logic [2:0]          phase_next;
  logic [LEN_BITS-1:0] remaining;
  logic [LEN_BITS-1:0] remaining_next;
  logic [2:0]          match_pos;
  logic [2:0]          match_pos_next;
  logic                match_alive;
  logic                match_alive_next;
  logic                first_part;
  logic                first_part_next;
  logic                halted;
  logic                halted_next;

  logic                res_push;
  res_t                res;

  logic [LEN_BITS+3:0] rem_ext;
  logic [LEN_BITS+3:0] rem_acc;
  logic                acc_ovf;
  logic [LEN_BITS-1:0] digit_ext;
  logic                rem_zero;
  logic                rem_one;

  res_t                oq [2];
  logic                oq_wptr;
  logic                oq_rptr;
  logic [1:0]          oq_count;
  logic                oq_pop;

  // Take a command whenever the result queue has room.
  assign cmd_pop = !cmd_empty && (oq_count != 2'd2);

  // Decimal accumulation: remaining * 10 + digit, with overflow check.
  assign rem_ext   = {4'b0000, remaining};
  assign rem_acc   = (rem_ext << 3) + (rem_ext << 1) + {{LEN_BITS{1'b0}}, cmd.digit};
  assign acc_ovf   = |rem_acc[LEN_BITS+3:LEN_BITS];
  assign digit_ext = {{(LEN_BITS-4){1'b0}}, cmd.digit};
  assign rem_zero  = (remaining == '0);
  assign rem_one   = (remaining == {{(LEN_BITS-1){1'b0}}, 1'b1});

  // Parser state machine: one command per cycle while a command waits and the result queue has room.
  always_comb begin
    phase_next       = phase;
    remaining_next   = remaining;
    match_pos_next   = match_pos;
    match_alive_next = match_alive;
    first_part_next  = first_part;
    halted_next      = halted;
    res_push         = 1'b0;
    res.kind         = KIND_CHAR;
    res.ch           = 8'h00;
    res.code         = ERR_NONE;

    if (cmd_pop && !halted) begin
      case (phase)
        PH_TOP: begin
          case (cmd.cls)
            CLS_END: begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res.kind    = KIND_END;
            end
            CLS_INT: phase_next = PH_INT;
            CLS_LIST, CLS_DICT, CLS_CLOSE: phase_next = phase;
            CLS_DIGIT: begin
              remaining_next = digit_ext;
              phase_next     = PH_LEN;
            end
            default: begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res.kind    = KIND_ERR;
              res.code    = ERR_BAD_START;
            end
          endcase
        end
        PH_INT: begin
          if (cmd.cls == CLS_END) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_TRUNC_INT;
          end else if (cmd.cls == CLS_CLOSE) begin
            phase_next = PH_TOP;
          end
        end
        PH_LEN, PH_PLEN: begin
          if (cmd.cls == CLS_DIGIT) begin
            if (acc_ovf) begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res.kind    = KIND_ERR;
              res.code    = ERR_LEN_OVF;
            end else begin
              remaining_next = rem_acc[LEN_BITS-1:0];
            end
          end else if (cmd.cls != CLS_COLON) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_NO_COLON;
          end else if (phase == PH_LEN) begin
            if (rem_zero) begin
              phase_next = PH_TOP;
            end else begin
              match_pos_next   = 3'd0;
              match_alive_next = (remaining == LEN_BITS'(4));
              phase_next       = PH_BODY;
            end
          end else if (rem_zero) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_EMPTY_NAME;
          end else begin
            // A later part gets its separator when its length prefix closes.
            phase_next = PH_PBODY;
            if (!first_part) begin
              res_push = 1'b1;
              res.ch   = CH_SLASH;
            end else begin
              first_part_next = 1'b0;
            end
          end
        end
        PH_BODY: begin
          if (cmd.cls == CLS_END) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_SHORT_STR;
          end else begin
            if (match_alive) begin
              if (match_pos[2] || key_byte(match_pos[1:0]) != cmd.data) begin
                match_alive_next = 1'b0;
              end
              match_pos_next = match_pos + 3'd1;
            end
            remaining_next = remaining - 1'b1;
            if (rem_one) begin
              phase_next = match_alive_next ? PH_WANT_LIST : PH_TOP;
            end
          end
        end
        PH_WANT_LIST: begin
          if (cmd.cls != CLS_LIST) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_NO_LIST;
          end else begin
            first_part_next = 1'b1;
            phase_next      = PH_ITEM;
          end
        end
        PH_ITEM: begin
          if (cmd.cls == CLS_CLOSE) begin
            if (first_part) begin
              halted_next = 1'b1;
              res_push    = 1'b1;
              res.kind    = KIND_ERR;
              res.code    = ERR_EMPTY_PATH;
            end else begin
              first_part_next = 1'b1;
              phase_next      = PH_TOP;
              res_push        = 1'b1;
              res.ch          = CH_NEWLINE;
            end
          end else if (cmd.cls == CLS_DIGIT) begin
            remaining_next = digit_ext;
            phase_next     = PH_PLEN;
          end else begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_BAD_ITEM;
          end
        end
        PH_PBODY: begin
          if (cmd.cls == CLS_END) begin
            halted_next = 1'b1;
            res_push    = 1'b1;
            res.kind    = KIND_ERR;
            res.code    = ERR_SHORT_STR;
          end else begin
            remaining_next = remaining - 1'b1;
            if (rem_one) begin
              phase_next = PH_ITEM;
            end
            res_push = 1'b1;
            res.ch   = cmd.data;
          end
        end
        default: phase_next = PH_TOP;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TOP;
      remaining   <= '0;
      match_pos   <= 3'd0;
      match_alive <= 1'b0;
      first_part  <= 1'b1;
      halted      <= 1'b0;
    end else begin
      phase       <= phase_next;
      remaining   <= remaining_next;
      match_pos   <= match_pos_next;
      match_alive <= match_alive_next;
      first_part  <= first_part_next;
      halted      <= halted_next;
    end
  end

  // Two-entry result queue toward the receiver.
  assign oq_pop     = pop && !empty;
  assign empty      = (oq_count == 2'd0);
  assign out_kind   = oq[oq_rptr].kind;
  assign out_char   = oq[oq_rptr].ch;
  assign error_code = oq[oq_rptr].code;

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq[oq_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= 1'b0;
      oq_rptr  <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wptr <= ~oq_wptr;
      end
      if (oq_pop) begin
        oq_rptr <= ~oq_rptr;
      end
      if (res_push && !oq_pop) begin
        oq_count <= oq_count + 2'd1;
      end else if (oq_pop && !res_push) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

  assign stat.halted   = halted;
  assign stat.res_push = res_push;

endmodule

/* hdl/bencode_path_extractor.sv */
// Top level of the bencode path extractor.
// Depends on bpe_pkg, bpe_front, bpe_queue and bpe_back.
//
// Usage:
//   Input channel: one bencoded byte per transaction on in_byte, or an end
//   marker with is_end high. A transaction is taken when push is high and
//   full is low. Output channel: results appear while empty is low and are
//   taken when pop is high. Each result is a path character ('/' and newline
//   included), one error with its code, or a clean end of input.
// Throughput: one byte per cycle while the result queue has room, set by the
//   parser step in the back end; the front classifies bytes into a four-entry
//   command queue. Path: a byte that yields a result is registered in the
//   command queue, and its result in the result queue, before it shows.
// Stalls: while the receiver does not pop, the two-entry result queue fills,
//   the parser stops taking commands, and full rises once the command queue
//   holds four bytes.
// Reset: rst is synchronous; it empties both queues and returns the parser to
//   the top level. After an error or end result the block drops all input
//   until the next reset.
module bencode_path_extractor
  import bpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_char,
  output logic [3:0] error_code
);

  cmd_t  front_cmd;
  cmd_t  back_cmd;
  logic  cq_empty;
  logic  cq_pop;
  stat_t stat;

  // Byte classification.
  bpe_front u_front (
    .in_byte (in_byte),
    .is_end  (is_end),
    .cmd     (front_cmd)
  );

  // Command queue between front and back.
  bpe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (cq_pop),
    .dout  (back_cmd),
    .empty (cq_empty)
  );

  // Parser and result queue.
  bpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .cmd_empty  (cq_empty),
    .cmd_pop    (cq_pop),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .out_char   (out_char),
    .error_code (error_code),
    .stat       (stat)
  );

`ifndef SYNTHESIS
  // A halted parser never produces another result.
  assert property (@(posedge clk) disable iff (rst) stat.halted |-> !stat.res_push)
    else $error("result produced after halt");

  // An error or end result is the last one, so the queue drains behind it.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_kind != KIND_CHAR) |=> empty)
    else $error("result queued behind an error or end");

  // Character and end results carry no error code; errors always carry one.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_kind == KIND_ERR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // Once halted, the parser stays halted until reset.
  assert property (@(posedge clk) disable iff (rst) stat.halted |=> stat.halted)
    else $error("halt state cleared without reset");
`endif

endmodule

/* tb/tb_bencode_path_extractor.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bencode_path_extractor: directed bytes, then a random
// well-formed stream that closes on one clean end or one error, checked by a local parser.
// Depends on bpe_pkg and the RTL of bencode_path_extractor.
module tb_bencode_path_extractor;
  import bpe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTS  = 10;

  // Bytes that steer the parser.
  localparam logic [7:0] CH_INT   = "i";
  localparam logic [7:0] CH_LIST  = "l";
  localparam logic [7:0] CH_DICT  = "d";
  localparam logic [7:0] CH_CLOSE = "e";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_MINUS = "-";

  // Directed rows either use the parser model or carry a typed expectation.
  localparam logic PREDICT = 1'b0;
  localparam logic TYPED   = 1'b1;

  typedef enum logic [3:0] {
    ST_TOKEN, ST_INTEGER, ST_STR_LEN, ST_STR_BODY,
    ST_NEED_LIST, ST_PART_START, ST_PART_LEN, ST_PART_BODY
  } parse_state_t;

  // One input transaction, with an optional typed expectation.
  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    logic       has;
    res_t       want;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       is_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_char;
  logic [3:0] error_code;

  // Parser model state.
  parse_state_t ph = ST_TOKEN;
  logic [63:0]  str_left = '0;
  logic [2:0]   key_pos = '0;
  logic         key_live = 1'b0;
  logic         first_seg = 1'b1;
  logic         stopped = 1'b0;
  logic [31:0]  key_word = "path";

  res_t  pending_results[$];
  stim_t byte_stream[$];

  int  cycle_count = 0;
  int  full_stalls = 0;
  int  mismatches = 0;
  int  bytes_taken = 0;
  int  directed_count = 0;
  int  results_seen = 0;
  int  path_chars = 0;
  int  closing_case = 0;
  int  hold_cycles = 0;
  bit  burst = 1'b0;
  bit  drain_fast = 1'b0;

  bencode_path_extractor i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .is_end     (is_end),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .out_char   (out_char),
    .error_code (error_code)
  );

  always #2 clk = ~clk;

  // Cycle count, input stall count and the run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (push && full) full_stalls++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected.",
               cycle_count, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // An error halts the parser until reset.
  function automatic res_t fault(input logic [3:0] c);
    stopped = 1'b1;
    return {KIND_ERR, 8'h00, c};
  endfunction

  // Moves the parser model by one byte and returns the result it causes, if any.
  function automatic void advance_parser(input logic [7:0] b, input logic fin,
                                         output logic produced, output res_t r);
    logic [63:0] dval;
    logic [63:0] lim;
    dval = {56'd0, b - CH_ZERO};
    lim = {64{1'b1}} >> (64 - LEN_BITS);
    produced = 1'b0;
    r = '0;
    if (stopped) return;
    case (ph)
      ST_TOKEN: begin
        if (fin) begin
          stopped = 1'b1;
          produced = 1'b1;
          r = {KIND_END, 8'h00, ERR_NONE};
        end else if (b == CH_INT) begin
          ph = ST_INTEGER;
        end else if (b == CH_LIST || b == CH_DICT || b == CH_CLOSE) begin
          // Container markers carry nothing at token level.
        end else if (is_num(b)) begin
          str_left = dval;
          ph = ST_STR_LEN;
        end else begin
          produced = 1'b1;
          r = fault(ERR_BAD_START);
        end
      end
      ST_INTEGER: begin
        if (fin) begin
          produced = 1'b1;
          r = fault(ERR_TRUNC_INT);
        end else if (b == CH_CLOSE) begin
          ph = ST_TOKEN;
        end
      end
      ST_STR_LEN, ST_PART_LEN: begin
        produced = 1'b1;
        if (fin) begin
          r = fault(ERR_NO_COLON);
        end else if (is_num(b)) begin
          if (str_left > (lim - dval) / 10) begin
            r = fault(ERR_LEN_OVF);
          end else begin
            str_left = str_left * 10 + dval;
            produced = 1'b0;
          end
        end else if (b != CH_COLON) begin
          r = fault(ERR_NO_COLON);
        end else if (ph == ST_STR_LEN) begin
          produced = 1'b0;
          if (str_left == 0) begin
            ph = ST_TOKEN;
          end else begin
            key_pos = '0;
            key_live = (str_left == 4);
            ph = ST_STR_BODY;
          end
        end else if (str_left == 0) begin
          r = fault(ERR_EMPTY_NAME);
        end else begin
          // The separator goes out on the colon of every later path part.
          ph = ST_PART_BODY;
          if (!first_seg) begin
            r = {KIND_CHAR, CH_SLASH, ERR_NONE};
          end else begin
            produced = 1'b0;
            first_seg = 1'b0;
          end
        end
      end
      ST_STR_BODY: begin
        if (fin) begin
          produced = 1'b1;
          r = fault(ERR_SHORT_STR);
        end else begin
          if (key_live) begin
            if (key_pos > 3 || key_word[8 * (3 - key_pos[1:0]) +: 8] != b) key_live = 1'b0;
            key_pos = key_pos + 3'd1;
          end
          str_left = str_left - 1;
          if (str_left == 0) ph = key_live ? ST_NEED_LIST : ST_TOKEN;
        end
      end
      ST_NEED_LIST: begin
        if (fin || b != CH_LIST) begin
          produced = 1'b1;
          r = fault(ERR_NO_LIST);
        end else begin
          first_seg = 1'b1;
          ph = ST_PART_START;
        end
      end
      ST_PART_START: begin
        produced = 1'b1;
        if (fin) begin
          r = fault(ERR_BAD_ITEM);
        end else if (b == CH_CLOSE) begin
          if (first_seg) begin
            r = fault(ERR_EMPTY_PATH);
          end else begin
            first_seg = 1'b1;
            ph = ST_TOKEN;
            r = {KIND_CHAR, CH_NEWLINE, ERR_NONE};
          end
        end else if (!is_num(b)) begin
          r = fault(ERR_BAD_ITEM);
        end else begin
          produced = 1'b0;
          str_left = dval;
          ph = ST_PART_LEN;
        end
      end
      ST_PART_BODY: begin
        produced = 1'b1;
        if (fin) begin
          r = fault(ERR_SHORT_STR);
        end else begin
          str_left = str_left - 1;
          if (str_left == 0) ph = ST_PART_START;
          r = {KIND_CHAR, b, ERR_NONE};
        end
      end
      default: ph = ST_TOKEN;
    endcase
  endfunction

  // Stream building.
  task automatic add_row(input logic [7:0] b, input logic typed, input logic has,
                         input logic [7:0] ch);
    stim_t s;
    s.b = b;
    s.fin = 1'b0;
    s.typed = typed;
    s.has = has;
    s.want = {KIND_CHAR, ch, ERR_NONE};
    byte_stream.push_back(s);
  endtask

  task automatic put(input logic [7:0] b);
    add_row(b, PREDICT, 1'b0, 8'h00);
  endtask

  task automatic put_end();
    stim_t s;
    s = '0;
    s.b = 8'($urandom_range(0, 255));
    s.fin = 1'b1;
    byte_stream.push_back(s);
  endtask

  task automatic put_text(input string txt);
    for (int i = 0; i < txt.len(); i++) put(txt[i]);
  endtask

  // Length prefix, sometimes with a leading zero, and its colon.
  task automatic put_len(input int n);
    if ($urandom_range(0, 7) == 0) put(CH_ZERO);
    put_text($sformatf("%0d", n));
    put(CH_COLON);
  endtask

  task automatic gen_path_entry();
    int n;
    put_len(4);
    put_text("path");
    put(CH_LIST);
    repeat ($urandom_range(1, 4)) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
      put_len(n);
      repeat (n) put(8'($urandom_range(0, 255)));
    end
    put(CH_CLOSE);
  endtask

  task automatic gen_string();
    int k;
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: begin
        // Four bytes that differ from the key word in one bit.
        k = $urandom_range(0, 3);
        put_len(4);
        for (int i = 0; i < 4; i++) begin
          b = key_word[8 * (3 - i) +: 8];
          if (i == k) b = b ^ (8'h01 << $urandom_range(0, 7));
          put(b);
        end
      end
      1: begin
        put_len(5);
        put_text("path");
        put(8'($urandom_range(0, 255)));
      end
      default: begin
        k = $urandom_range(0, 12);
        put_len(k);
        repeat (k) put(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic gen_int();
    logic [7:0] b;
    put(CH_INT);
    if ($urandom_range(0, 3) == 0) put(CH_MINUS);
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_CLOSE) b = CH_INT;
      put(b);
    end
    put(CH_CLOSE);
  endtask

  // The one clean end or error that closes the stream.
  task automatic gen_closing(input int which);
    logic [7:0] b;
    case (which)
      ERR_BAD_START: begin
        do b = 8'($urandom_range(0, 255));
        while (is_num(b) || b == CH_INT || b == CH_LIST || b == CH_DICT || b == CH_CLOSE);
        put(b);
      end
      ERR_LEN_OVF: put_text("99999999999999999999999");
      ERR_NO_COLON: begin
        put_text($sformatf("%0d", {64{1'b1}} >> (64 - LEN_BITS)));
        if ($urandom_range(0, 1) == 0) begin
          put_end();
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (is_num(b) || b == CH_COLON);
          put(b);
        end
      end
      ERR_SHORT_STR: begin
        put_text("5:");
        put(8'($urandom_range(0, 255)));
        put(8'($urandom_range(0, 255)));
        put_end();
      end
      ERR_NO_LIST: begin
        put_text("4:path");
        if ($urandom_range(0, 1) == 0) begin
          put_end();
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_LIST);
          put(b);
        end
      end
      ERR_BAD_ITEM: begin
        put_text("4:pathl");
        if ($urandom_range(0, 1) == 0) put_text("1:a");
        if ($urandom_range(0, 1) == 0) begin
          put_end();
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (is_num(b) || b == CH_CLOSE);
          put(b);
        end
      end
      ERR_EMPTY_NAME: begin
        put_text("4:pathl");
        if ($urandom_range(0, 1) == 0) put_text("1:a");
        put_text("0:");
      end
      ERR_EMPTY_PATH: put_text("4:pathle");
      ERR_TRUNC_INT: begin
        put_text("i12");
        put_end();
      end
      default: put_end();
    endcase
  endtask

  // Sender side: optional gap, then hold push until the transaction is taken.
  task automatic offer(input stim_t s);
    int   gap;
    logic got;
    res_t r;
    gap = burst ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= s.b;
    is_end <= s.fin;
    do @(posedge clk); while (full);
    advance_parser(s.b, s.fin, got, r);
    if (s.typed) begin
      got = s.has;
      r = s.want;
    end
    if (got) pending_results.push_back(r);
    bytes_taken++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("Mismatch %0d: %s", mismatches, msg);
  endtask

  // Receiver side: random pops, one long hold on request, field-by-field check.
  initial begin : result_side
    int   gap;
    res_t got;
    res_t want;
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      gap = drain_fast ? 0 : $urandom_range(0, 5);
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = {out_kind, out_char, error_code};
      results_seen++;
      if (got.kind == KIND_CHAR) path_chars++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: kind %0d char %02h code %0d",
                                got.kind, got.ch, got.code));
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.ch != want.ch || got.code != want.code)
          note_mismatch($sformatf({"expected kind %0d char %02h code %0d, ",
                                   "got kind %0d char %02h code %0d"},
                                  want.kind, want.ch, want.code,
                                  got.kind, got.ch, got.code));
      end
      if (results_seen % 64 == 0) drain_fast = ($urandom_range(0, 2) == 0);
    end
  end

  // Main sequence: reset, directed rows, random stream, closing case, drain.
  initial begin : stimulus
    int mid;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: markers, an integer, an empty string, the key word and a
    // two-part path with zero and all-ones bytes and a separator.
    add_row(CH_DICT, TYPED, 1'b0, 8'h00);
    add_row(CH_INT, PREDICT, 1'b0, 8'h00);
    add_row(8'hFF, PREDICT, 1'b0, 8'h00);
    add_row(CH_CLOSE, PREDICT, 1'b0, 8'h00);
    add_row("0", PREDICT, 1'b0, 8'h00);
    add_row(CH_COLON, PREDICT, 1'b0, 8'h00);
    add_row("4", PREDICT, 1'b0, 8'h00);
    add_row(CH_COLON, PREDICT, 1'b0, 8'h00);
    add_row("p", PREDICT, 1'b0, 8'h00);
    add_row("a", PREDICT, 1'b0, 8'h00);
    add_row("t", PREDICT, 1'b0, 8'h00);
    add_row("h", PREDICT, 1'b0, 8'h00);
    add_row(CH_LIST, PREDICT, 1'b0, 8'h00);
    add_row("2", PREDICT, 1'b0, 8'h00);
    add_row(CH_COLON, TYPED, 1'b0, 8'h00);
    add_row(8'h00, TYPED, 1'b1, 8'h00);
    add_row(8'hFF, TYPED, 1'b1, 8'hFF);
    add_row("1", PREDICT, 1'b0, 8'h00);
    add_row(CH_COLON, TYPED, 1'b1, CH_SLASH);
    add_row(8'h80, TYPED, 1'b1, 8'h80);
    add_row(CH_CLOSE, TYPED, 1'b1, CH_NEWLINE);
    add_row(CH_CLOSE, PREDICT, 1'b0, 8'h00);
    directed_count = byte_stream.size();
    foreach (byte_stream[i]) offer(byte_stream[i]);
    pause_until_drained();

    // Random stream: mostly well-formed tokens, path lists among them.
    byte_stream.delete();
    gen_path_entry();
    while (byte_stream.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2:       put($urandom_range(0, 2) == 0 ? CH_LIST :
                           ($urandom_range(0, 1) == 0 ? CH_DICT : CH_CLOSE));
        3, 4, 5, 6:    gen_int();
        7, 8, 9, 10, 11, 12: gen_string();
        default:       gen_path_entry();
      endcase
    end
    mid = byte_stream.size() / 2;
    closing_case = $urandom_range(0, 9);
    gen_closing(closing_case);
    // A halted parser must ignore whatever follows.
    put_end();
    repeat (4) put(8'($urandom_range(0, 255)));

    // The receiver holds off while the sender runs without gaps.
    hold_cycles = LONG_HOLD;
    burst = 1'b1;
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i >= 200 && i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == mid) pause_until_drained();
      offer(byte_stream[i]);
    end
    @(negedge clk);
    push <= 1'b0;

    // Drain, then give late extra results a chance to show.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes (%0d directed) and checked %0d results, %0d path characters.",
             bytes_taken, directed_count, results_seen, path_chars);
    $display("Closing case %0d (0 is a clean end, else the error code); stalled %0d cycles.",
             closing_case, full_stalls);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
